// File: hdl/mvse_pkg.sv
package mvse_pkg;

    localparam int FB_BYTES = 16384;
    localparam int FB_AW    = $clog2(FB_BYTES);
    localparam int ADDR_W   = 21;

    localparam logic [7:0] PIX_MSB   = 8'h80;
    localparam logic [9:0] PACK_ROWS = 10'd8;

    typedef enum logic [1:0] {
        OP_DRAW = 2'd0,
        OP_PUT  = 2'd1,
        OP_GET  = 2'd2,
        OP_NONE = 2'd3
    } op_t;

    typedef enum logic [2:0] {
        CFG_STRIDE      = 3'd0,
        CFG_CLIP_LEFT   = 3'd1,
        CFG_CLIP_TOP    = 3'd2,
        CFG_CLIP_RIGHT  = 3'd3,
        CFG_CLIP_BOTTOM = 3'd4,
        CFG_FG_BIT      = 3'd5,
        CFG_PACKED      = 3'd6
    } cfg_idx_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_CLIP,
        ST_ADDR,
        ST_READ,
        ST_MODIFY,
        ST_DONE
    } state_t;

    typedef struct packed {
        logic       drop;
        logic [9:0] y_start;
        logic [9:0] rows;
        logic [2:0] skip;
    } clip_t;

endpackage

// File: hdl/mvse_clip.sv
module mvse_clip
(
    input  mvse_pkg::op_t   op,
    input  logic [9:0]      x,
    input  logic [9:0]      y,
    input  logic [9:0]      height,
    input  logic [9:0]      clip_left,
    input  logic [9:0]      clip_top,
    input  logic [10:0]     clip_right,
    input  logic [10:0]     clip_bottom,
    input  logic            packed_mode,
    output mvse_pkg::clip_t res
);

    logic [9:0]         hl;
    logic               x_out;
    logic signed [12:0] y_s;
    logic signed [12:0] top_s;
    logic signed [12:0] bot_s;
    logic signed [12:0] ys;
    logic signed [12:0] sk;
    logic signed [12:0] hh;
    logic               drop_clip;

    always_comb
    begin
        if (op == mvse_pkg::OP_DRAW)
        begin
            hl = height;
        end
        else if (packed_mode)
        begin
            hl = (height > mvse_pkg::PACK_ROWS) ? mvse_pkg::PACK_ROWS : height;
        end
        else
        begin
            hl = (height > 10'd1) ? 10'd1 : height;
        end

        x_out = (x < clip_left) || ({1'b0, x} >= clip_right);
        y_s   = $signed({3'b000, y});
        top_s = $signed({3'b000, clip_top});
        bot_s = $signed({2'b00, clip_bottom});

        if (y_s < top_s)
        begin
            ys = top_s;
            sk = top_s - y_s;
        end
        else
        begin
            ys = y_s;
            sk = '0;
        end

        hh = $signed({3'b000, hl}) - sk;
        if (ys + hh > bot_s)
        begin
            hh = bot_s - ys;
        end
        drop_clip = x_out || (hh <= 13'sd0);

        case (op)
            mvse_pkg::OP_DRAW, mvse_pkg::OP_PUT:
            begin
                res.drop    = drop_clip;
                res.y_start = ys[9:0];
                res.rows    = drop_clip ? 10'd0 : hh[9:0];
                res.skip    = sk[2:0];
            end
            mvse_pkg::OP_GET:
            begin
                res.drop    = 1'b0;
                res.y_start = y;
                res.rows    = hl;
                res.skip    = 3'd0;
            end
            default:
            begin
                res.drop    = 1'b1;
                res.y_start = y;
                res.rows    = 10'd0;
                res.skip    = 3'd0;
            end
        endcase
    end

endmodule

// File: hdl/mono_vertical_span_engine.sv
// Vertical-span engine over a one-bit-per-pixel framebuffer of 16384 bytes
// held in a single-port synchronous RAM. One item is worked at a time: after
// the input transfer it clips the span, forms the start address (x byte plus
// row times stride), then for each row touched reads the RAM, then modifies
// and writes back, and last hands the result to the output register, waiting
// while a result there is still unaccepted. The next item is taken while a
// finished result still waits in the output register. The frame RAM is not
// cleared at reset; read only pixels that were written.
module mono_vertical_span_engine
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_we,
    input  logic [2:0]  cfg_index,
    input  logic [10:0] cfg_data,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic [1:0]  op,
    input  logic [9:0]  x,
    input  logic [9:0]  y,
    input  logic [9:0]  height,
    input  logic [7:0]  data,
    output logic        out_valid,
    input  logic        out_ready,
    output logic [7:0]  read_data,
    output logic [9:0]  rows_done
);

    logic [7:0]  stride_reg;
    logic [9:0]  clip_left_reg;
    logic [9:0]  clip_top_reg;
    logic [10:0] clip_right_reg;
    logic [10:0] clip_bottom_reg;
    logic        fg_reg;
    logic        packed_reg;

    mvse_pkg::state_t state_reg, state_next;
    mvse_pkg::op_t    op_reg, op_next;
    logic [9:0]  x_reg, x_next;
    logic [9:0]  y_reg, y_next;
    logic [9:0]  height_reg, height_next;
    logic [7:0]  data_reg, data_next;
    mvse_pkg::clip_t clip_reg, clip_next;
    mvse_pkg::clip_t clip_res;
    logic [mvse_pkg::ADDR_W-1:0] addr_reg, addr_next;
    logic [9:0]  rows_left_reg, rows_left_next;
    logic [7:0]  src_reg, src_next;
    logic [7:0]  sel_reg, sel_next;
    logic [7:0]  rd_reg, rd_next;
    logic        out_valid_reg, out_valid_next;
    logic [7:0]  read_data_reg, read_data_next;
    logic [9:0]  rows_done_reg, rows_done_next;

    logic [7:0]  mem [mvse_pkg::FB_BYTES];
    logic [7:0]  mem_q;
    logic        mem_re;
    logic        mem_we;
    logic [7:0]  mem_wdata;
    logic [mvse_pkg::FB_AW-1:0] mem_idx;

    logic [7:0]  pix_mask;
    logic        in_rng;
    logic        pix_bit;
    logic        wval;
    logic [17:0] row_off;

    mvse_clip u_clip
    (
        .op          (op_reg),
        .x           (x_reg),
        .y           (y_reg),
        .height      (height_reg),
        .clip_left   (clip_left_reg),
        .clip_top    (clip_top_reg),
        .clip_right  (clip_right_reg),
        .clip_bottom (clip_bottom_reg),
        .packed_mode (packed_reg),
        .res         (clip_res)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            stride_reg      <= 8'd32;
            clip_left_reg   <= 10'd0;
            clip_top_reg    <= 10'd0;
            clip_right_reg  <= 11'd256;
            clip_bottom_reg <= 11'd512;
            fg_reg          <= 1'b1;
            packed_reg      <= 1'b1;
        end
        else if (cfg_we)
        begin
            case (mvse_pkg::cfg_idx_t'(cfg_index))
                mvse_pkg::CFG_STRIDE:      stride_reg      <= cfg_data[7:0];
                mvse_pkg::CFG_CLIP_LEFT:   clip_left_reg   <= cfg_data[9:0];
                mvse_pkg::CFG_CLIP_TOP:    clip_top_reg    <= cfg_data[9:0];
                mvse_pkg::CFG_CLIP_RIGHT:  clip_right_reg  <= cfg_data;
                mvse_pkg::CFG_CLIP_BOTTOM: clip_bottom_reg <= cfg_data;
                mvse_pkg::CFG_FG_BIT:      fg_reg          <= cfg_data[0];
                mvse_pkg::CFG_PACKED:      packed_reg      <= cfg_data[0];
                default:                   ;
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            mem[mem_idx] <= mem_wdata;
        end
        if (mem_re)
        begin
            mem_q <= mem[mem_idx];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= mvse_pkg::ST_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        op_reg        <= op_next;
        x_reg         <= x_next;
        y_reg         <= y_next;
        height_reg    <= height_next;
        data_reg      <= data_next;
        clip_reg      <= clip_next;
        addr_reg      <= addr_next;
        rows_left_reg <= rows_left_next;
        src_reg       <= src_next;
        sel_reg       <= sel_next;
        rd_reg        <= rd_next;
        read_data_reg <= read_data_next;
        rows_done_reg <= rows_done_next;
    end

    assign mem_idx  = addr_reg[mvse_pkg::FB_AW-1:0];
    assign pix_mask = mvse_pkg::PIX_MSB >> x_reg[2:0];
    assign in_rng   = addr_reg < mvse_pkg::ADDR_W'(mvse_pkg::FB_BYTES);
    assign pix_bit  = in_rng && ((mem_q & pix_mask) != 8'd0);
    assign row_off  = 18'(clip_reg.y_start) * 18'(stride_reg);

    always_comb
    begin
        state_next     = state_reg;
        op_next        = op_reg;
        x_next         = x_reg;
        y_next         = y_reg;
        height_next    = height_reg;
        data_next      = data_reg;
        clip_next      = clip_reg;
        addr_next      = addr_reg;
        rows_left_next = rows_left_reg;
        src_next       = src_reg;
        sel_next       = sel_reg;
        rd_next        = rd_reg;
        read_data_next = read_data_reg;
        rows_done_next = rows_done_reg;
        out_valid_next = out_valid_reg && !out_ready;
        in_ready       = 1'b0;
        mem_re         = 1'b0;
        mem_we         = 1'b0;
        wval           = 1'b0;
        mem_wdata      = mem_q;

        case (state_reg)
            mvse_pkg::ST_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    op_next     = mvse_pkg::op_t'(op);
                    x_next      = x;
                    y_next      = y;
                    height_next = height;
                    data_next   = data;
                    state_next  = mvse_pkg::ST_CLIP;
                end
            end
            mvse_pkg::ST_CLIP:
            begin
                clip_next      = clip_res;
                rows_left_next = clip_res.rows;
                src_next       = data_reg << clip_res.skip;
                sel_next       = mvse_pkg::PIX_MSB;
                rd_next        = 8'd0;
                state_next     = mvse_pkg::ST_ADDR;
            end
            mvse_pkg::ST_ADDR:
            begin
                addr_next  = mvse_pkg::ADDR_W'(x_reg[9:3]) + mvse_pkg::ADDR_W'(row_off);
                state_next = (clip_reg.rows == 10'd0) ? mvse_pkg::ST_DONE
                                                      : mvse_pkg::ST_READ;
            end
            mvse_pkg::ST_READ:
            begin
                mem_re     = 1'b1;
                state_next = mvse_pkg::ST_MODIFY;
            end
            mvse_pkg::ST_MODIFY:
            begin
                if (op_reg == mvse_pkg::OP_DRAW)
                begin
                    wval = fg_reg;
                end
                else
                begin
                    wval = packed_reg ? src_reg[7] : data_reg[0];
                end
                mem_wdata = wval ? (mem_q | pix_mask) : (mem_q & ~pix_mask);
                mem_we    = in_rng && (op_reg != mvse_pkg::OP_GET);
                if (op_reg == mvse_pkg::OP_GET)
                begin
                    rd_next = packed_reg ? (rd_reg | (pix_bit ? sel_reg : 8'd0))
                                         : {7'd0, pix_bit};
                end
                addr_next      = addr_reg + mvse_pkg::ADDR_W'(stride_reg);
                rows_left_next = rows_left_reg - 10'd1;
                src_next       = {src_reg[6:0], 1'b0};
                sel_next       = {1'b0, sel_reg[7:1]};
                state_next     = (rows_left_reg == 10'd1) ? mvse_pkg::ST_DONE
                                                          : mvse_pkg::ST_READ;
            end
            mvse_pkg::ST_DONE:
            begin
                if (!out_valid_reg || out_ready)
                begin
                    read_data_next = rd_reg;
                    rows_done_next = clip_reg.rows;
                    out_valid_next = 1'b1;
                    state_next     = mvse_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = mvse_pkg::ST_IDLE;
            end
        endcase
    end

    assign out_valid = out_valid_reg;
    assign read_data = read_data_reg;
    assign rows_done = rows_done_reg;

endmodule

// File: hdl/mvse_checker.sv
module mvse_checker
(
    input logic        clk,
    input logic        rst_n,
    input logic        in_valid,
    input logic        in_ready,
    input logic        out_valid,
    input logic        out_ready,
    input logic [7:0]  read_data,
    input logic [9:0]  rows_done
);

    logic in_xfer;

    assign in_xfer = in_valid && in_ready;

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(read_data) && $stable(rows_done))
        else $error("result changed while stalled");

    a_one_item: assert property (@(posedge clk) disable iff (!rst_n)
        in_xfer |=> !in_ready)
        else $error("second item taken while one is in work");

    a_no_instant_result: assert property (@(posedge clk) disable iff (!rst_n)
        in_xfer |=> !$rose(out_valid))
        else $error("result shown the cycle after a transfer");

    a_read_rows: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && (read_data != 8'd0) |-> (rows_done != 10'd0) && (rows_done <= 10'd8))
        else $error("read data on a result that read no rows or too many");

endmodule

bind mono_vertical_span_engine mvse_checker u_mvse_checker (.*);

// File: verif/tb.sv
module tb;

    localparam int STALL_LIMIT = 20000;
    localparam int RANDOM_PER_PHASE = 170;

    typedef struct packed {
        logic [7:0] rd;
        logic [9:0] rows;
    } span_result_t;

    typedef struct {
        bit                 is_cfg;
        mvse_pkg::cfg_idx_t idx;
        int                 val;
        mvse_pkg::op_t      kind;
        int                 px;
        int                 py;
        int                 ph;
        int                 pd;
        bit                 typed;
        int                 rd;
        int                 rows;
    } plan_row_t;

    typedef struct {
        int pitch;
        int x0;
        int y0;
        int x1;
        int y1;
        int ink;
        int pk;
    } regs_t;

    logic        clk = 1'b0;
    logic        rst_n;
    logic        cfg_we;
    logic [2:0]  cfg_index;
    logic [10:0] cfg_data;
    logic        in_valid;
    logic        in_ready;
    logic [1:0]  op;
    logic [9:0]  x;
    logic [9:0]  y;
    logic [9:0]  height;
    logic [7:0]  data;
    logic        out_valid;
    logic        out_ready = 1'b0;
    logic [7:0]  read_data;
    logic [9:0]  rows_done;

    // pixel image of the frame and which of its bits have been written
    bit [7:0] frame_bits [mvse_pkg::FB_BYTES];
    bit [7:0] frame_known [mvse_pkg::FB_BYTES];
    int row_pitch;
    int clip_x0;
    int clip_y0;
    int clip_x1;
    int clip_y1;
    bit ink;
    bit packed_px;

    span_result_t expected_spans[$];
    int spot_x[$];
    int spot_y[$];
    bit calm = 1'b0;
    int errors = 0;
    int checked = 0;
    int idle_cycles = 0;
    int n_draw = 0;
    int n_put = 0;
    int n_get = 0;
    int n_none = 0;

    plan_row_t plan [28] = '{
        '{0, mvse_pkg::CFG_STRIDE, 0, mvse_pkg::OP_NONE, 1023, 1023, 1023, 'hFF, 1, 0, 0},
        '{0, mvse_pkg::CFG_STRIDE, 0, mvse_pkg::OP_GET, 0, 600, 1023, 0, 1, 0, 8},
        '{0, mvse_pkg::CFG_STRIDE, 0, mvse_pkg::OP_GET, 1023, 1023, 0, 0, 1, 0, 0},
        '{0, mvse_pkg::CFG_STRIDE, 0, mvse_pkg::OP_DRAW, 256, 0, 10, 0, 1, 0, 0},
        '{0, mvse_pkg::CFG_STRIDE, 0, mvse_pkg::OP_DRAW, 0, 0, 0, 0, 1, 0, 0},
        '{0, mvse_pkg::CFG_STRIDE, 0, mvse_pkg::OP_DRAW, 0, 500, 1023, 0, 1, 0, 12},
        '{0, mvse_pkg::CFG_STRIDE, 0, mvse_pkg::OP_DRAW, 255, 510, 5, 0, 1, 0, 2},
        '{0, mvse_pkg::CFG_STRIDE, 0, mvse_pkg::OP_PUT, 0, 0, 8, 'hA5, 1, 0, 8},
        '{0, mvse_pkg::CFG_STRIDE, 0, mvse_pkg::OP_GET, 0, 0, 8, 0, 1, 'hA5, 8},
        '{0, mvse_pkg::CFG_STRIDE, 0, mvse_pkg::OP_PUT, 7, 508, 1023, 'hFF, 1, 0, 4},
        '{0, mvse_pkg::CFG_STRIDE, 0, mvse_pkg::OP_GET, 7, 508, 4, 0, 1, 'hF0, 4},
        '{0, mvse_pkg::CFG_STRIDE, 0, mvse_pkg::OP_PUT, 255, 1023, 8, 'hFF, 1, 0, 0},
        '{0, mvse_pkg::CFG_STRIDE, 0, mvse_pkg::OP_GET, 0, 0, 3, 0, 1, 'hA0, 3},
        '{0, mvse_pkg::CFG_STRIDE, 0, mvse_pkg::OP_GET, 1023, 1023, 1023, 0, 1, 0, 8},
        '{0, mvse_pkg::CFG_STRIDE, 0, mvse_pkg::OP_DRAW, 0, 0, 8, 0, 1, 0, 8},
        '{0, mvse_pkg::CFG_STRIDE, 0, mvse_pkg::OP_GET, 0, 0, 8, 0, 1, 'hFF, 8},
        '{0, mvse_pkg::CFG_STRIDE, 0, mvse_pkg::OP_PUT, 0, 2, 1, 'h7F, 1, 0, 1},
        '{0, mvse_pkg::CFG_STRIDE, 0, mvse_pkg::OP_GET, 0, 0, 8, 0, 1, 'hDF, 8},
        '{0, mvse_pkg::CFG_STRIDE, 0, mvse_pkg::OP_GET, 0, 500, 8, 0, 1, 'hFF, 8},
        '{0, mvse_pkg::CFG_STRIDE, 0, mvse_pkg::OP_GET, 0, 511, 8, 0, 1, 'h80, 8},
        '{1, mvse_pkg::CFG_CLIP_TOP, 4, mvse_pkg::OP_NONE, 0, 0, 0, 0, 0, 0, 0},
        '{0, mvse_pkg::CFG_STRIDE, 0, mvse_pkg::OP_PUT, 8, 0, 8, 'h5A, 1, 0, 4},
        '{0, mvse_pkg::CFG_STRIDE, 0, mvse_pkg::OP_GET, 8, 4, 4, 0, 0, 0, 0},
        '{1, mvse_pkg::CFG_PACKED, 0, mvse_pkg::OP_NONE, 0, 0, 0, 0, 0, 0, 0},
        '{0, mvse_pkg::CFG_STRIDE, 0, mvse_pkg::OP_PUT, 9, 4, 5, 'h01, 1, 0, 1},
        '{0, mvse_pkg::CFG_STRIDE, 0, mvse_pkg::OP_GET, 9, 4, 7, 0, 0, 0, 0},
        '{1, mvse_pkg::CFG_PACKED, 1, mvse_pkg::OP_NONE, 0, 0, 0, 0, 0, 0, 0},
        '{1, mvse_pkg::CFG_CLIP_TOP, 0, mvse_pkg::OP_NONE, 0, 0, 0, 0, 0, 0, 0}
    };

    regs_t phases [8] = '{
        '{32, 0, 0, 256, 512, 1, 1},
        '{1, 0, 0, 1024, 1024, 0, 1},
        '{128, 16, 8, 200, 100, 1, 0},
        '{64, 1023, 1023, 1024, 1024, 1, 1},
        '{17, 40, 20, 0, 0, 0, 1},
        '{8, 100, 3, 30, 60, 1, 1},
        '{32, 0, 0, 256, 512, 1, 1},
        '{32, 0, 5, 128, 300, 0, 0}
    };

    mono_vertical_span_engine DUT
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .op        (op),
        .x         (x),
        .y         (y),
        .height    (height),
        .data      (data),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .read_data (read_data),
        .rows_done (rows_done)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    function automatic int frame_addr(int px, int row);
        return (px >> 3) + row * row_pitch;
    endfunction

    function automatic int span_limit(int ph);
        int lim;
        lim = packed_px ? 8 : 1;
        return (ph > lim) ? lim : ph;
    endfunction

    function automatic span_result_t predict_span(mvse_pkg::op_t kind, int px, int py,
                                                  int ph, int pd);
        span_result_t r;
        int row0;
        int rows;
        int skip;
        int i;
        int a;
        bit v;
        logic [7:0] src;
        r = '0;
        row0 = py;
        rows = ph;
        skip = 0;
        src = pd[7:0];
        if (kind == mvse_pkg::OP_PUT || kind == mvse_pkg::OP_GET)
            rows = span_limit(ph);
        if (kind == mvse_pkg::OP_DRAW || kind == mvse_pkg::OP_PUT)
        begin
            if (row0 < clip_y0)
            begin
                skip = clip_y0 - row0;
                row0 = clip_y0;
                rows -= skip;
            end
            if (row0 + rows > clip_y1)
                rows = clip_y1 - row0;
            if (px >= clip_x0 && px < clip_x1 && rows > 0)
            begin
                for (i = 0; i < rows; i++)
                begin
                    if (kind == mvse_pkg::OP_DRAW)
                        v = ink;
                    else
                        v = packed_px ? src[7 - skip - i] : src[0];
                    a = frame_addr(px, row0 + i);
                    if (a < mvse_pkg::FB_BYTES)
                    begin
                        frame_bits[a][7 - (px & 7)] = v;
                        frame_known[a][7 - (px & 7)] = 1'b1;
                    end
                end
                r.rows = rows[9:0];
            end
        end
        else if (kind == mvse_pkg::OP_GET)
        begin
            for (i = 0; i < rows; i++)
            begin
                a = frame_addr(px, py + i);
                v = (a < mvse_pkg::FB_BYTES) ? frame_bits[a][7 - (px & 7)] : 1'b0;
                if (packed_px)
                    r.rd[7 - i] = v;
                else
                    r.rd = {7'b0, v};
            end
            r.rows = rows[9:0];
        end
        return r;
    endfunction

    function automatic bit readable(int px, int py, int ph);
        int i;
        int a;
        for (i = 0; i < span_limit(ph); i++)
        begin
            a = frame_addr(px, py + i);
            if (a < mvse_pkg::FB_BYTES && !frame_known[a][7 - (px & 7)])
                return 1'b0;
        end
        return 1'b1;
    endfunction

    function automatic int near(int lo, int hi_ex);
        int r;
        int e;
        r = $urandom_range(99);
        if (r < 65 && lo < hi_ex && lo <= 1023)
            return $urandom_range((hi_ex - 1 > 1023) ? 1023 : hi_ex - 1, lo);
        if (r < 85)
        begin
            case ($urandom_range(3))
                0: e = lo - $urandom_range(8);
                1: e = lo;
                2: e = hi_ex - 1;
                default: e = hi_ex;
            endcase
            return (e < 0) ? 0 : ((e > 1023) ? 1023 : e);
        end
        return $urandom_range(1023);
    endfunction

    task automatic set_reg(mvse_pkg::cfg_idx_t idx, int val);
        cfg_we = 1'b1;
        cfg_index = idx;
        cfg_data = val[10:0];
        @(negedge clk);
        cfg_we = 1'b0;
        case (idx)
            mvse_pkg::CFG_STRIDE:      row_pitch = val & 'hFF;
            mvse_pkg::CFG_CLIP_LEFT:   clip_x0 = val & 'h3FF;
            mvse_pkg::CFG_CLIP_TOP:    clip_y0 = val & 'h3FF;
            mvse_pkg::CFG_CLIP_RIGHT:  clip_x1 = val & 'h7FF;
            mvse_pkg::CFG_CLIP_BOTTOM: clip_y1 = val & 'h7FF;
            mvse_pkg::CFG_FG_BIT:      ink = val[0];
            mvse_pkg::CFG_PACKED:      packed_px = val[0];
            default: ;
        endcase
    endtask

    task automatic apply_regs(regs_t s);
        set_reg(mvse_pkg::CFG_STRIDE, s.pitch);
        set_reg(mvse_pkg::CFG_CLIP_LEFT, s.x0);
        set_reg(mvse_pkg::CFG_CLIP_TOP, s.y0);
        set_reg(mvse_pkg::CFG_CLIP_RIGHT, s.x1);
        set_reg(mvse_pkg::CFG_CLIP_BOTTOM, s.y1);
        set_reg(mvse_pkg::CFG_FG_BIT, s.ink);
        set_reg(mvse_pkg::CFG_PACKED, s.pk);
    endtask

    // hold off the sender until every outstanding result is back
    task automatic drain();
        in_valid = 1'b0;
        while (expected_spans.size() != 0)
            @(negedge clk);
    endtask

    task automatic issue_span(mvse_pkg::op_t kind, int px, int py, int ph, int pd,
                              bit typed, int trd, int trows);
        span_result_t want;
        want = predict_span(kind, px, py, ph, pd);
        if (typed)
        begin
            want.rd = trd[7:0];
            want.rows = trows[9:0];
        end
        case (kind)
            mvse_pkg::OP_DRAW: n_draw++;
            mvse_pkg::OP_PUT:  n_put++;
            mvse_pkg::OP_GET:  n_get++;
            default: n_none++;
        endcase
        if ((kind == mvse_pkg::OP_DRAW || kind == mvse_pkg::OP_PUT) && want.rows != 0)
        begin
            spot_x.push_back(px);
            spot_y.push_back((py < clip_y0) ? clip_y0 : py);
            if (spot_x.size() > 16)
            begin
                void'(spot_x.pop_front());
                void'(spot_y.pop_front());
            end
        end
        while (!calm && $urandom_range(99) < 31)
        begin
            in_valid = 1'b0;
            @(negedge clk);
        end
        in_valid = 1'b1;
        op = kind;
        x = px[9:0];
        y = py[9:0];
        height = ph[9:0];
        data = pd[7:0];
        do @(posedge clk); while (!in_ready);
        expected_spans.push_back(want);
        @(negedge clk);
    endtask

    always @(negedge clk)
        out_ready = calm || ($urandom_range(99) >= 31);

    always @(posedge clk)
    begin
        span_result_t want;
        if (rst_n && out_valid && out_ready)
        begin
            if (expected_spans.size() == 0)
            begin
                errors++;
                $display("%0t: unexpected transfer read_data %h rows_done %0d",
                         $time, read_data, rows_done);
            end
            else
            begin
                want = expected_spans.pop_front();
                checked++;
                if (read_data !== want.rd)
                begin
                    errors++;
                    $display("%0t: read_data expected %h actual %h", $time, want.rd, read_data);
                end
                if (rows_done !== want.rows)
                begin
                    errors++;
                    $display("%0t: rows_done expected %0d actual %0d",
                             $time, want.rows, rows_done);
                end
            end
        end
    end

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((in_valid && in_ready) || (out_valid && out_ready))
                idle_cycles = 0;
            else
                idle_cycles++;
            if (idle_cycles >= STALL_LIMIT)
            begin
                $display("%0t: no transfer for %0d cycles, %0d results outstanding",
                         $time, idle_cycles, expected_spans.size());
                $display("DONE: errors detected");
                $finish;
            end
        end
    end

    initial
    begin
        int p;
        int n;
        int k;
        int r;
        int px;
        int py;
        int ph;
        int pd;
        mvse_pkg::op_t kind;
        rst_n = 1'b0;
        cfg_we = 1'b0;
        cfg_index = mvse_pkg::CFG_STRIDE;
        cfg_data = '0;
        in_valid = 1'b0;
        op = mvse_pkg::OP_NONE;
        x = '0;
        y = '0;
        height = '0;
        data = '0;
        row_pitch = 32;
        clip_x0 = 0;
        clip_y0 = 0;
        clip_x1 = 256;
        clip_y1 = 512;
        ink = 1'b1;
        packed_px = 1'b1;
        repeat (9) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        for (n = 0; n < $size(plan); n++)
        begin
            if (plan[n].is_cfg)
            begin
                drain();
                set_reg(plan[n].idx, plan[n].val);
            end
            else
                issue_span(plan[n].kind, plan[n].px, plan[n].py, plan[n].ph, plan[n].pd,
                           plan[n].typed, plan[n].rd, plan[n].rows);
        end

        // clear a block of the frame so later reads have defined pixels
        drain();
        apply_regs('{32, 0, 0, 1024, 1024, 0, 1});
        for (n = 0; n < 64; n++)
            issue_span(mvse_pkg::OP_DRAW, n, 0, 64, 0, 1'b0, 0, 0);

        for (p = 0; p < 8; p++)
        begin
            drain();
            if (p == 6)
                phases[p] = '{$urandom_range(128, 1), $urandom_range(600),
                              $urandom_range(600), $urandom_range(1024),
                              $urandom_range(1024), $urandom_range(1), $urandom_range(1)};
            apply_regs(phases[p]);
            calm = (p == 1);
            for (n = 0; n < RANDOM_PER_PHASE; n++)
            begin
                if ($urandom_range(99) == 0)
                    drain();
                r = $urandom_range(99);
                px = near(clip_x0, clip_x1);
                py = near(clip_y0, clip_y1);
                pd = $urandom_range(255);
                ph = ($urandom_range(6) == 0) ? $urandom_range(1023) : $urandom_range(9);
                if (r < 30)
                    kind = mvse_pkg::OP_PUT;
                else if (r < 65)
                begin
                    kind = mvse_pkg::OP_GET;
                    k = $urandom_range(99);
                    if (spot_x.size() != 0 && k < 50)
                    begin
                        k = $urandom_range(spot_x.size() - 1);
                        px = spot_x[k];
                        py = spot_y[k] - $urandom_range(2);
                        if (py < 0)
                            py = 0;
                    end
                    else if (k < 80)
                    begin
                        px = $urandom_range(63);
                        py = $urandom_range(63);
                    end
                    else
                    begin
                        px = $urandom_range(1023);
                        py = $urandom_range(1023);
                    end
                    if (!readable(px, py, ph))
                        kind = mvse_pkg::OP_PUT;
                end
                else if (r < 95)
                begin
                    kind = mvse_pkg::OP_DRAW;
                    k = $urandom_range(99);
                    if (k < 85)
                        ph = $urandom_range(16);
                    else if (k < 95)
                        ph = $urandom_range(100);
                    else
                        ph = $urandom_range(1023);
                end
                else
                begin
                    kind = mvse_pkg::OP_NONE;
                    px = $urandom_range(1023);
                    py = $urandom_range(1023);
                    ph = $urandom_range(1023);
                end
                issue_span(kind, px, py, ph, pd, 1'b0, 0, 0);
            end
        end

        drain();
        calm = 1'b0;
        repeat (50) @(posedge clk);
        $display("Sent %0d draws, %0d puts, %0d gets and %0d unused ops over %0d register sets",
                 n_draw, n_put, n_get, n_none, $size(phases) + 1);
        $display("Checked %0d results, %0d still outstanding", checked, expected_spans.size());
        if (errors == 0 && expected_spans.size() == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

endmodule
